// ===== rtl/gdc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdc_pkg: shared constants and types of the Geneve decap classifier
// Header layout constants, verdict codes, inner ethertype codes and the
// configuration register map.
// ----------------------------------------------------------------------------
package gdc_pkg;

	// tunnel slots the mask can carry
	localparam int MAX_TUNNELS = 4;

	// field widths
	localparam int VNI_W      = 24;
	localparam int POS_W      = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int HOLD_DEPTH = 14;
	localparam int HOLD_IDX_W = 4;

	// header and frame layout
	localparam logic [POS_W-1:0]      FIXED_HEADER  = 9'd8;
	localparam logic [POS_W-1:0]      POS_MAX       = 9'd511;
	localparam logic [HOLD_IDX_W-1:0] ETYPE_OFFSET  = 4'd12;
	localparam logic [HOLD_IDX_W-1:0] HOLD_LAST     = 4'd13;
	localparam logic [HOLD_IDX_W-1:0] HOLD_FULL     = 4'd14;
	localparam logic [15:0]           PROTO_ETHERNET = 16'h6558;
	localparam logic [7:0]            ETYPE_IPV4_HI = 8'h08;
	localparam logic [7:0]            ETYPE_IPV4_LO = 8'h00;
	localparam logic [7:0]            ETYPE_IPV6_HI = 8'h86;
	localparam logic [7:0]            ETYPE_IPV6_LO = 8'hDD;

	// reset values of the filter registers
	localparam logic [VNI_W-1:0] IPV4_ONLY_RESET = 24'd4096;
	localparam logic [VNI_W-1:0] IPV6_ONLY_RESET = 24'd8192;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_TUNNEL_VNI_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TUNNEL_EN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IPV4_ONLY    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IPV6_ONLY    = 3'd6;

	// verdict codes
	typedef enum logic [2:0] {
		ST_FORWARD   = 3'd0,
		ST_BAD_PROTO = 3'd1,
		ST_NOT_IPV4  = 3'd2,
		ST_NOT_IPV6  = 3'd3,
		ST_NO_TUNNEL = 3'd4,
		ST_SHORT_HDR = 3'd5
	} status_t;

	// inner ethertype codes
	typedef enum logic [1:0] {
		IK_NONE = 2'd0,
		IK_IPV4 = 2'd1,
		IK_IPV6 = 2'd2
	} ip_kind_t;

endpackage

// ===== rtl/geneve_decap_classifier.sv =====
// ----------------------------------------------------------------------------
// geneve_decap_classifier: Geneve decapsulation and tunnel classification
// Parses the Geneve header byte by byte, holds the first inner-frame bytes
// until the ethertype is known, filters and forwards the inner frame with a
// tunnel match mask, and closes each packet with a verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, in_byte, in_last) takes one packet byte
//   per request. Output channel (out_valid/out_stall) delivers forwarded inner
//   bytes (kind 0) and one verdict per packet (kind 1, out_last set).
//   Configuration is written through cfg_we/cfg_index/cfg_data; the user must
//   write it only while idle; the block does not enforce it. A taken byte
//   is registered in the result-sequencing stage, then moved into the output
//   register. Throughput: one byte per cycle while the output does not stall
//   and at most one result of the previous byte is left. A byte releasing
//   the held inner bytes causes up to 14 held bytes plus the verdict as
//   results, a forwarded last byte the byte and the verdict; the single
//   result-sequencing stage issues them one at a time. A request is taken
//   while the previous one's last result moves into the output register, so
//   a result waiting under out_stall does not block one new request. While
//   the receiver stalls, the output register holds. Reset clears the packet
//   parser, sequencer and output valid; registers return to reset values.
// ----------------------------------------------------------------------------
module geneve_decap_classifier
	import gdc_pkg::*;
#(
	parameter int NUM_TUNNELS = MAX_TUNNELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VNI_W-1:0]     cfg_data,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 kind,
	output logic [7:0]           data_byte,
	output logic [MAX_TUNNELS-1:0] dest_mask,
	output logic [VNI_W-1:0]     packet_vni,
	output logic [2:0]           status,
	output logic [1:0]           ip_kind,
	output logic                 out_last
);

	// configuration registers
	logic [VNI_W-1:0]       tvni_q [NUM_TUNNELS];
	logic [NUM_TUNNELS-1:0] ten_q;
	logic [VNI_W-1:0]       v4_vni_q;
	logic [VNI_W-1:0]       v6_vni_q;

	// packet parser state
	logic [POS_W-1:0]       pos_q;
	logic [POS_W-1:0]       hlen_q;
	logic [15:0]            proto_q;
	logic [VNI_W-1:0]       vni_q;
	status_t                drop_q;
	logic [MAX_TUNNELS-1:0] mask_q;
	ip_kind_t               ikind_q;
	logic [7:0]             hold_q [HOLD_DEPTH];

	// result sequencer stage
	logic [HOLD_IDX_W-1:0]  flush_left_s1;
	logic [HOLD_IDX_W-1:0]  flush_idx_s1;
	logic                   fwd_s1;
	logic                   verd_s1;
	logic [7:0]             fwd_byte_s1;
	status_t                status_s1;
	logic [MAX_TUNNELS-1:0] mask_s1;
	logic [VNI_W-1:0]       vni_s1;
	ip_kind_t               ikind_s1;

	// output register
	logic                   out_valid_s2;
	logic                   kind_s2;
	logic [7:0]             data_s2;
	logic [MAX_TUNNELS-1:0] mask_s2;
	logic [VNI_W-1:0]       vni_s2;
	status_t                status_s2;
	ip_kind_t               ikind_s2;
	logic                   last_s2;

	// next-state of the parser
	logic [POS_W-1:0]       pos_n;
	logic [POS_W-1:0]       hlen_n;
	logic [15:0]            proto_n;
	logic [VNI_W-1:0]       vni_n;
	status_t                drop_n;
	logic [MAX_TUNNELS-1:0] mask_n;
	ip_kind_t               ikind_n;
	logic                   in_hdr;
	logic                   short_hdr;
	logic                   do_decide;
	logic                   hold_we;
	logic                   fwd_n;
	logic [POS_W-1:0]       idx;
	logic [HOLD_IDX_W-1:0]  dec_count;
	logic [HOLD_IDX_W-1:0]  flush_cnt;
	status_t                verd_status;
	logic [VNI_W-1:0]       vni_full;
	logic [MAX_TUNNELS-1:0] match;

	// sequencer handshake
	logic                   accept;
	logic                   out_ready;
	logic                   job_any;
	logic                   job_one;
	logic                   take;

	// match the completed VNI against the enabled tunnel slots
	assign vni_full = {vni_q[VNI_W-1:8], in_byte};

	always_comb begin
		match = '0;
		for (int i = 0; i < NUM_TUNNELS; i++) begin
			match[i] = ten_q[i] && (tvni_q[i] == vni_full);
		end
	end

	// parse one byte: header fields, frame hold, decision, verdict
	always_comb begin
		pos_n       = pos_q;
		hlen_n      = hlen_q;
		proto_n     = proto_q;
		vni_n       = vni_q;
		drop_n      = drop_q;
		mask_n      = mask_q;
		ikind_n     = ikind_q;
		short_hdr   = 1'b0;
		do_decide   = 1'b0;
		hold_we     = 1'b0;
		fwd_n       = 1'b0;
		dec_count   = '0;
		flush_cnt   = '0;
		in_hdr      = pos_q < hlen_q;
		idx         = pos_q - hlen_q;

		if (in_hdr) begin
			case (pos_q)
				9'd0: hlen_n = FIXED_HEADER + {1'b0, in_byte[5:0], 2'b00};
				9'd2: proto_n = {in_byte, 8'h00};
				9'd3: begin
					proto_n = {proto_q[15:8], in_byte};
					if ({proto_q[15:8], in_byte} != PROTO_ETHERNET) begin
						drop_n = ST_BAD_PROTO;
					end
				end
				9'd4: vni_n = {in_byte, 16'h0000};
				9'd5: vni_n = {vni_q[VNI_W-1:16], in_byte, 8'h00};
				9'd6: begin
					vni_n  = vni_full;
					mask_n = match;
				end
				default: ;
			endcase
			if (in_last && (({1'b0, pos_q} + 10'd1) < {1'b0, hlen_n})) begin
				short_hdr = 1'b1;
			end
		end else begin
			if (idx < POS_W'(HOLD_DEPTH)) begin
				hold_we = 1'b1;
				if (idx[HOLD_IDX_W-1:0] == HOLD_LAST) begin
					do_decide = 1'b1;
					dec_count = HOLD_FULL;
				end
			end else if (drop_q == ST_FORWARD) begin
				fwd_n = 1'b1;
			end
		end

		// packet ends before the ethertype: decide on what is held
		if (in_last && !short_hdr &&
		    ({1'b0, pos_q} < ({1'b0, hlen_n} + 10'(HOLD_LAST)))) begin
			do_decide = 1'b1;
			dec_count = in_hdr ? '0 : idx[HOLD_IDX_W-1:0] + 4'd1;
		end

		// ethertype, filters and flush length
		if (do_decide) begin
			ikind_n = IK_NONE;
			if (dec_count == HOLD_FULL) begin
				if (hold_q[ETYPE_OFFSET] == ETYPE_IPV4_HI && in_byte == ETYPE_IPV4_LO) begin
					ikind_n = IK_IPV4;
				end else if (hold_q[ETYPE_OFFSET] == ETYPE_IPV6_HI &&
				             in_byte == ETYPE_IPV6_LO) begin
					ikind_n = IK_IPV6;
				end
			end
			if (drop_n == ST_FORWARD) begin
				if (vni_n == v4_vni_q && ikind_n != IK_IPV4) begin
					drop_n = ST_NOT_IPV4;
				end else if (vni_n == v6_vni_q && ikind_n != IK_IPV6) begin
					drop_n = ST_NOT_IPV6;
				end else if (mask_n == '0) begin
					drop_n = ST_NO_TUNNEL;
				end
			end
			flush_cnt = (drop_n == ST_FORWARD) ? dec_count : '0;
		end

		verd_status = short_hdr ? ST_SHORT_HDR : drop_n;

		// advance the position, saturating on long packets
		if (!in_last && pos_q != POS_MAX) begin
			pos_n = pos_q + 9'd1;
		end
	end

	// sequencer: one result per cycle into the output register while it is not stalled
	assign out_ready = !out_valid_s2 || !out_stall;
	assign job_any   = (flush_left_s1 != '0) || fwd_s1 || verd_s1;
	assign job_one   = ((flush_left_s1 == 4'd1) && !fwd_s1 && !verd_s1) ||
	                   ((flush_left_s1 == '0) && (fwd_s1 ^ verd_s1));
	assign take      = job_any && out_ready;
	assign in_stall  = job_any && !(job_one && out_ready);
	assign accept    = in_valid && !in_stall;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TUNNELS; i++) begin
				tvni_q[i] <= '0;
			end
			ten_q         <= '0;
			v4_vni_q      <= IPV4_ONLY_RESET;
			v6_vni_q      <= IPV6_ONLY_RESET;
			pos_q         <= '0;
			hlen_q        <= FIXED_HEADER;
			proto_q       <= '0;
			vni_q         <= '0;
			drop_q        <= ST_FORWARD;
			mask_q        <= '0;
			ikind_q       <= IK_NONE;
			flush_left_s1 <= '0;
			flush_idx_s1  <= '0;
			fwd_s1        <= 1'b0;
			verd_s1       <= 1'b0;
			out_valid_s2  <= 1'b0;
		end else begin
			// register writes
			if (cfg_we) begin
				for (int i = 0; i < NUM_TUNNELS; i++) begin
					if (cfg_index == REG_TUNNEL_VNI_0 + CFG_IDX_W'(i)) begin
						tvni_q[i] <= cfg_data;
					end
				end
				if (cfg_index == REG_TUNNEL_EN) begin
					ten_q <= cfg_data[NUM_TUNNELS-1:0];
				end
				if (cfg_index == REG_IPV4_ONLY) begin
					v4_vni_q <= cfg_data;
				end
				if (cfg_index == REG_IPV6_ONLY) begin
					v6_vni_q <= cfg_data;
				end
			end

			// parser update, cleared after every verdict
			if (accept) begin
				if (in_last) begin
					pos_q   <= '0;
					hlen_q  <= FIXED_HEADER;
					proto_q <= '0;
					vni_q   <= '0;
					drop_q  <= ST_FORWARD;
					mask_q  <= '0;
					ikind_q <= IK_NONE;
				end else begin
					pos_q   <= pos_n;
					hlen_q  <= hlen_n;
					proto_q <= proto_n;
					vni_q   <= vni_n;
					drop_q  <= drop_n;
					mask_q  <= mask_n;
					ikind_q <= ikind_n;
				end
			end

			// load a new job or advance the current one
			if (accept) begin
				flush_left_s1 <= flush_cnt;
				flush_idx_s1  <= '0;
				fwd_s1        <= fwd_n;
				verd_s1       <= in_last;
			end else if (take) begin
				if (flush_left_s1 != '0) begin
					flush_left_s1 <= flush_left_s1 - 4'd1;
					flush_idx_s1  <= flush_idx_s1 + 4'd1;
				end else if (fwd_s1) begin
					fwd_s1 <= 1'b0;
				end else begin
					verd_s1 <= 1'b0;
				end
			end

			// output valid: hold while stalled
			if (out_ready) begin
				out_valid_s2 <= job_any;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && hold_we) begin
			hold_q[idx[HOLD_IDX_W-1:0]] <= in_byte;
		end
		if (accept) begin
			fwd_byte_s1 <= in_byte;
			status_s1   <= verd_status;
			mask_s1     <= mask_n;
			vni_s1      <= vni_n;
			ikind_s1    <= ikind_n;
		end
		if (take) begin
			mask_s2  <= mask_s1;
			vni_s2   <= vni_s1;
			ikind_s2 <= ikind_s1;
			if (flush_left_s1 != '0) begin
				kind_s2   <= 1'b0;
				data_s2   <= hold_q[flush_idx_s1];
				status_s2 <= ST_FORWARD;
				last_s2   <= 1'b0;
			end else if (fwd_s1) begin
				kind_s2   <= 1'b0;
				data_s2   <= fwd_byte_s1;
				status_s2 <= ST_FORWARD;
				last_s2   <= 1'b0;
			end else begin
				kind_s2   <= 1'b1;
				data_s2   <= 8'h00;
				status_s2 <= status_s1;
				last_s2   <= 1'b1;
			end
		end
	end

	// drive the output ports
	assign out_valid  = out_valid_s2;
	assign kind       = kind_s2;
	assign data_byte  = data_s2;
	assign dest_mask  = mask_s2;
	assign packet_vni = vni_s2;
	assign status     = status_s2;
	assign ip_kind    = ikind_s2;
	assign out_last   = last_s2;

endmodule

// ===== verif/gdc_checker.sv =====
// ----------------------------------------------------------------------------
// gdc_checker: result checker for the Geneve decap classifier
// Watches the configuration port and both request channels, keeps its own
// copy of the header parser, hold buffer and filters, predicts every
// forwarded byte and verdict, and compares each result field by field.
// ----------------------------------------------------------------------------
module gdc_checker
	import gdc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [VNI_W-1:0]       cfg_data,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [7:0]             in_byte,
	input  logic                   in_last,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic                   kind,
	input  logic [7:0]             data_byte,
	input  logic [MAX_TUNNELS-1:0] dest_mask,
	input  logic [VNI_W-1:0]       packet_vni,
	input  logic [2:0]             status,
	input  logic [1:0]             ip_kind,
	input  logic                   out_last,
	output int                     fail_count,
	output int                     pending,
	output int                     checked
);

	typedef struct {
		logic                   kind;
		logic [7:0]             data;
		logic [MAX_TUNNELS-1:0] mask;
		logic [VNI_W-1:0]       vni;
		status_t                status;
		ip_kind_t               ikind;
		logic                   last;
	} gdc_result_t;

	// register copies
	logic [VNI_W-1:0]       slot_vni [MAX_TUNNELS];
	logic [MAX_TUNNELS-1:0] slot_en;
	logic [VNI_W-1:0]       v4_only_vni;
	logic [VNI_W-1:0]       v6_only_vni;

	// packet parser copy
	logic [POS_W-1:0]       byte_pos;
	logic [POS_W-1:0]       hdr_len;
	logic [15:0]            proto;
	logic [VNI_W-1:0]       cur_vni;
	logic [7:0]             held_bytes [HOLD_DEPTH];
	status_t                drop;
	logic [MAX_TUNNELS-1:0] tunnel_hits;
	ip_kind_t               inner_type;

	gdc_result_t frame_out_q [$];
	gdc_result_t head;
	int errs = 0;
	int seen = 0;

	// return the parser to the start of a packet
	function automatic void restart_packet();
		byte_pos    = '0;
		hdr_len     = FIXED_HEADER;
		proto       = '0;
		cur_vni     = '0;
		drop        = ST_FORWARD;
		tunnel_hits = '0;
		inner_type  = IK_NONE;
	endfunction

	function automatic void queue_result(input logic k, input logic [7:0] d, input status_t st,
			input logic lst);
		gdc_result_t r;
		r.kind   = k;
		r.data   = d;
		r.mask   = tunnel_hits;
		r.vni    = cur_vni;
		r.status = st;
		r.ikind  = inner_type;
		r.last   = lst;
		frame_out_q.push_back(r);
	endfunction

	// classify the ethertype, apply the filters, release the held bytes
	function automatic void settle_frame(input int count);
		inner_type = IK_NONE;
		if (count == HOLD_DEPTH) begin
			if (held_bytes[ETYPE_OFFSET] == ETYPE_IPV4_HI && held_bytes[HOLD_LAST] == ETYPE_IPV4_LO)
				inner_type = IK_IPV4;
			else if (held_bytes[ETYPE_OFFSET] == ETYPE_IPV6_HI &&
					held_bytes[HOLD_LAST] == ETYPE_IPV6_LO)
				inner_type = IK_IPV6;
		end
		if (drop == ST_FORWARD) begin
			if (cur_vni == v4_only_vni && inner_type != IK_IPV4)
				drop = ST_NOT_IPV4;
			else if (cur_vni == v6_only_vni && inner_type != IK_IPV6)
				drop = ST_NOT_IPV6;
			else if (tunnel_hits == '0)
				drop = ST_NO_TUNNEL;
		end
		if (drop == ST_FORWARD) begin
			for (int i = 0; i < count && i < HOLD_DEPTH; i++)
				queue_result(1'b0, held_bytes[i], ST_FORWARD, 1'b0);
		end
	endfunction

	// predict the results of one accepted packet byte
	function automatic void parse_byte(input logic [7:0] b, input logic lst);
		int pos;
		int idx;
		int count;
		bit short_hdr;
		status_t st;
		pos       = int'(byte_pos);
		short_hdr = 1'b0;
		if (pos < int'(hdr_len)) begin
			case (pos)
				0: hdr_len = FIXED_HEADER + {1'b0, b[5:0], 2'b00};
				2: proto[15:8] = b;
				3: begin
					proto[7:0] = b;
					if (proto != PROTO_ETHERNET)
						drop = ST_BAD_PROTO;
				end
				4: cur_vni = {b, 16'h0000};
				5: cur_vni[15:8] = b;
				6: begin
					cur_vni[7:0] = b;
					tunnel_hits  = '0;
					for (int i = 0; i < MAX_TUNNELS; i++)
						if (slot_en[i] && slot_vni[i] == cur_vni)
							tunnel_hits[i] = 1'b1;
				end
				default: ;
			endcase
			// header length may just have grown from the option count
			if (lst && pos + 1 < int'(hdr_len))
				short_hdr = 1'b1;
		end else begin
			idx = pos - int'(hdr_len);
			if (idx < HOLD_DEPTH) begin
				held_bytes[idx] = b;
				if (idx == HOLD_DEPTH - 1)
					settle_frame(HOLD_DEPTH);
			end else if (drop == ST_FORWARD) begin
				queue_result(1'b0, b, ST_FORWARD, 1'b0);
			end
		end

		if (lst) begin
			if (short_hdr) begin
				st = ST_SHORT_HDR;
			end else begin
				// frame ended before the ethertype was complete
				if (pos < int'(hdr_len) + HOLD_DEPTH - 1) begin
					count = (pos >= int'(hdr_len)) ? pos - int'(hdr_len) + 1 : 0;
					settle_frame(count);
				end
				st = drop;
			end
			queue_result(1'b1, 8'h00, st, 1'b1);
			restart_packet();
		end else if (byte_pos < POS_MAX) begin
			byte_pos = POS_W'(pos + 1);
		end
	endfunction

	function automatic void check_field(input string name, input logic [VNI_W-1:0] want,
			input logic [VNI_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TUNNELS; i++)
				slot_vni[i] = '0;
			slot_en     = '0;
			v4_only_vni = IPV4_ONLY_RESET;
			v6_only_vni = IPV6_ONLY_RESET;
			restart_packet();
			frame_out_q.delete();
		end else begin
			// mirror register writes; unknown indexes are dropped
			if (cfg_we) begin
				case (cfg_index)
					REG_TUNNEL_EN: slot_en     = cfg_data[MAX_TUNNELS-1:0];
					REG_IPV4_ONLY: v4_only_vni = cfg_data;
					REG_IPV6_ONLY: v6_only_vni = cfg_data;
					default: begin
						if (cfg_index < REG_TUNNEL_EN)
							slot_vni[2'(cfg_index - REG_TUNNEL_VNI_0)] = cfg_data;
					end
				endcase
			end

			if (in_valid && !in_stall)
				parse_byte(in_byte, in_last);

			// compare each accepted result with the oldest prediction
			if (out_valid && !out_stall) begin
				if (frame_out_q.size() == 0) begin
					$error("unexpected result: kind %0d data 0x%0h status %0d last %0d",
						kind, data_byte, status, out_last);
					errs++;
				end else begin
					head = frame_out_q.pop_front();
					check_field("kind", VNI_W'(head.kind), VNI_W'(kind));
					check_field("data_byte", VNI_W'(head.data), VNI_W'(data_byte));
					check_field("dest_mask", VNI_W'(head.mask), VNI_W'(dest_mask));
					check_field("packet_vni", head.vni, packet_vni);
					check_field("status", VNI_W'(head.status), VNI_W'(status));
					check_field("ip_kind", VNI_W'(head.ikind), VNI_W'(ip_kind));
					check_field("out_last", VNI_W'(head.last), VNI_W'(out_last));
					seen++;
				end
			end
		end
		pending    <= frame_out_q.size();
		fail_count <= errs;
		checked    <= seen;
	end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the Geneve decap classifier
// Sends directed packets for each verdict and corner of the header and inner
// frame, then random packets under several register settings with random
// idling on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import gdc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 3'd7;
	localparam logic [15:0]          ETYPE_IPV4 = {ETYPE_IPV4_HI, ETYPE_IPV4_LO};
	localparam logic [15:0]          ETYPE_IPV6 = {ETYPE_IPV6_HI, ETYPE_IPV6_LO};

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [VNI_W-1:0]       cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic [7:0]             in_byte   = '0;
	logic                   in_last   = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   kind;
	logic [7:0]             data_byte;
	logic [MAX_TUNNELS-1:0] dest_mask;
	logic [VNI_W-1:0]       packet_vni;
	logic [2:0]             status;
	logic [1:0]             ip_kind;
	logic                   out_last;

	int fail_count;
	int pending;
	int checked;

	logic [VNI_W-1:0] cfg_copy [0:7];
	logic [7:0]       pkt [$];
	bit idle_on      = 1'b0;
	int stall_left   = 0;
	int bytes_sent   = 0;
	int packets_sent = 0;
	int settings     = 0;

	geneve_decap_classifier u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.dest_mask  (dest_mask),
		.packet_vni (packet_vni),
		.status     (status),
		.ip_kind    (ip_kind),
		.out_last   (out_last)
	);

	gdc_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.data_byte  (data_byte),
		.dest_mask  (dest_mask),
		.packet_vni (packet_vni),
		.status     (status),
		.ip_kind    (ip_kind),
		.out_last   (out_last),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stall the result side in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 7);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// offer one byte, with an optional idle burst first, and hold until taken
	task automatic send_byte(input logic [7:0] b, input logic lst);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic push_packet();
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
		packets_sent++;
	endtask

	// build the fixed header plus option words; version and flags are random
	task automatic make_header(input int opt, input logic [15:0] proto,
			input logic [VNI_W-1:0] vni);
		logic [7:0] b0;
		b0      = 8'($urandom);
		b0[5:0] = opt[5:0];
		pkt.delete();
		pkt.push_back(b0);
		pkt.push_back(8'($urandom));
		pkt.push_back(proto[15:8]);
		pkt.push_back(proto[7:0]);
		pkt.push_back(vni[23:16]);
		pkt.push_back(vni[15:8]);
		pkt.push_back(vni[7:0]);
		pkt.push_back(8'($urandom));
		repeat (4 * opt) pkt.push_back(8'($urandom));
	endtask

	// append inner frame bytes with the ethertype in its place
	task automatic add_inner(input int n, input logic [15:0] etype);
		for (int i = 0; i < n; i++) begin
			if (i == ETYPE_OFFSET)
				pkt.push_back(etype[15:8]);
			else if (i == HOLD_LAST)
				pkt.push_back(etype[7:0]);
			else
				pkt.push_back(8'($urandom));
		end
	endtask

	task automatic truncate(input int n);
		while (pkt.size() > n)
			void'(pkt.pop_back());
	endtask

	// wait until every predicted result has come, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input bit with_spare);
		for (int r = REG_TUNNEL_VNI_0; r <= REG_IPV6_ONLY; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(r);
			cfg_data  <= cfg_copy[r];
			@(posedge clk);
		end
		// an index past the map must change nothing
		if (with_spare) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_SPARE;
			cfg_data  <= VNI_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings++;
	endtask

	// pick VNIs from a small pool so slots and filters collide often
	task automatic random_config();
		for (int r = REG_TUNNEL_VNI_0; r <= REG_IPV6_ONLY; r++) begin
			if (r == REG_TUNNEL_EN) begin
				cfg_copy[r] = ($urandom_range(0, 1) != 0) ? VNI_W'(4'hF) :
					VNI_W'($urandom_range(0, 15));
			end else begin
				case ($urandom_range(0, 3))
					0:       cfg_copy[r] = '0;
					1:       cfg_copy[r] = '1;
					2:       cfg_copy[r] = cfg_copy[$urandom_range(REG_TUNNEL_VNI_0, REG_TUNNEL_EN - 1)];
					default: cfg_copy[r] = VNI_W'($urandom);
				endcase
			end
		end
	endtask

	// mostly well-formed packets, some noise, bad protocol and cut headers
	task automatic random_packet();
		int sel;
		int opt;
		int inner;
		logic [15:0] proto;
		logic [15:0] etype;
		logic [VNI_W-1:0] vni;
		sel = $urandom_range(0, 99);
		if (sel < 5) begin
			pkt.delete();
			repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom));
		end else begin
			opt   = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
			proto = (sel < 12) ? 16'($urandom) : PROTO_ETHERNET;
			vni   = ($urandom_range(0, 4) == 0) ? VNI_W'($urandom) :
				cfg_copy[$urandom_range(REG_TUNNEL_VNI_0, REG_IPV6_ONLY)];
			case ($urandom_range(0, 5))
				0, 1:    etype = ETYPE_IPV4;
				2, 3:    etype = ETYPE_IPV6;
				4:       etype = (($urandom_range(0, 1) != 0) ? ETYPE_IPV4 : ETYPE_IPV6) ^
					(16'd1 << $urandom_range(0, 15));
				default: etype = 16'($urandom);
			endcase
			inner = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) :
				HOLD_DEPTH + $urandom_range(0, 6);
			make_header(opt, proto, vni);
			add_inner(inner, etype);
			if (sel >= 93)
				truncate($urandom_range(1, 7 + 4 * opt));
		end
		push_packet();
	endtask

	initial begin
		int start;
		for (int r = REG_TUNNEL_VNI_0; r <= REG_SPARE; r++)
			cfg_copy[r] = '0;
		cfg_copy[REG_IPV4_ONLY] = IPV4_ONLY_RESET;
		cfg_copy[REG_IPV6_ONLY] = IPV6_ONLY_RESET;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;

		// reset registers: no slot enabled, filters at their reset VNIs
		pkt.delete();
		pkt.push_back(8'hFF);
		push_packet();
		make_header(0, PROTO_ETHERNET, '0);
		add_inner(16, ETYPE_IPV4);
		push_packet();
		make_header(1, PROTO_ETHERNET, IPV4_ONLY_RESET);
		add_inner(14, ETYPE_IPV6);
		push_packet();

		// directed slots: lowest VNI, highest VNI, a filtered VNI, one more
		drain();
		cfg_copy[REG_TUNNEL_VNI_0]     = '0;
		cfg_copy[REG_TUNNEL_VNI_0 + 1] = '1;
		cfg_copy[REG_TUNNEL_VNI_0 + 2] = IPV4_ONLY_RESET;
		cfg_copy[REG_TUNNEL_VNI_0 + 3] = 24'h123456;
		cfg_copy[REG_TUNNEL_EN]        = VNI_W'(4'hF);
		load_config(1'b1);

		// forward, bad protocol, each filter, no tunnel
		make_header(0, PROTO_ETHERNET, '1);
		add_inner(17, ETYPE_IPV4);
		push_packet();
		make_header(0, 16'h6559, '1);
		add_inner(16, ETYPE_IPV4);
		push_packet();
		make_header(0, PROTO_ETHERNET, IPV4_ONLY_RESET);
		add_inner(15, ETYPE_IPV4);
		push_packet();
		make_header(0, PROTO_ETHERNET, IPV4_ONLY_RESET);
		add_inner(13, ETYPE_IPV4);
		push_packet();
		make_header(0, PROTO_ETHERNET, IPV6_ONLY_RESET);
		add_inner(14, ETYPE_IPV4);
		push_packet();
		make_header(0, PROTO_ETHERNET, IPV6_ONLY_RESET);
		add_inner(14, ETYPE_IPV6);
		push_packet();
		// short inner frame and a frame that ends right at the header end
		make_header(2, PROTO_ETHERNET, '0);
		add_inner(5, ETYPE_IPV4);
		push_packet();
		make_header(2, PROTO_ETHERNET, '0);
		push_packet();
		// short headers, with the longest option count and with bad protocol
		make_header(63, PROTO_ETHERNET, '0);
		truncate(20);
		push_packet();
		make_header(0, 16'h0000, '0);
		truncate(4);
		push_packet();

		// random phases; the last one uses extreme settings and no idling
		for (int ph = 0; ph < 4; ph++) begin
			drain();
			if (ph == 3) begin
				for (int r = REG_TUNNEL_VNI_0; r < REG_TUNNEL_EN; r++)
					cfg_copy[r] = (r % 2 != 0) ? '1 : '0;
				cfg_copy[REG_TUNNEL_EN] = VNI_W'(4'hF);
				cfg_copy[REG_IPV4_ONLY] = '1;
				cfg_copy[REG_IPV6_ONLY] = '0;
			end else begin
				random_config();
			end
			load_config(ph == 0);
			start = bytes_sent;
			while (bytes_sent - start < 40) begin
				idle_on = (ph < 3) && ($urandom_range(0, 3) != 0);
				random_packet();
			end
		end
		drain();

		$display("Summary: %0d bytes in %0d packets under %0d register settings, %0d results compared",
			bytes_sent, packets_sent, settings, checked);
		if (fail_count == 0 && pending == 0)
			$display("[geneve_decap_classifier] OK");
		else
			$display("[geneve_decap_classifier] ERROR");
		$finish;
	end

	// hard limit on the run
	initial begin
		#10000000;
		$display("Timeout: %0d results still outstanding", pending);
		$display("[geneve_decap_classifier] ERROR");
		$finish;
	end

endmodule
